// ----- sv/metaphone_phoneme_encoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// Metaphone encoder assertion macros
// Concurrent check macros used at the end of the top level; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef METAPHONE_PHONEME_ENCODER_TOP_ASSERT_SVH
`define METAPHONE_PHONEME_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTH

// expr must hold at every clock edge out of reset
`define MPE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// ante implies cons in the same cycle
`define MPE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define MPE_ASSERT_ALWAYS(lbl, expr, msg)

`define MPE_ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/mpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Metaphone encoder package
// Shared widths, register indexes, the position job record and the letter table.
// ----------------------------------------------------------------------------
package mpe_pkg;

    localparam int LIMIT_BITS = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = LIMIT_BITS;

    localparam logic [CFG_ADDR_W-1:0] REG_PHONEME_LIMIT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_TRAD_MODE     = 1'b1;

    localparam int WIN_LEN = 8;
    localparam int CUR     = 4;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0] SH_CODE = 8'h58;  // 'X'
    localparam logic [7:0] TH_CODE = 8'h30;  // '0'

    // letter class bits
    localparam int CLS_VOWEL_BIT    = 0;
    localparam int CLS_AFFECT_H_BIT = 2;
    localparam int CLS_SOFT_BIT     = 3;
    localparam int CLS_NO_GH_F_BIT  = 4;

    localparam logic [4:0] LETTER_CLASS [26] = '{
        5'd1, 5'd16, 5'd4, 5'd16, 5'd9, 5'd2, 5'd4, 5'd16, 5'd9, 5'd2,
        5'd0, 5'd2, 5'd2, 5'd2, 5'd1, 5'd4, 5'd0, 5'd2, 5'd4, 5'd4,
        5'd1, 5'd0, 5'd0, 5'd0, 5'd8, 5'd0
    };

    // window element 0 is the oldest byte, CUR the position being encoded
    typedef logic [WIN_LEN-1:0][7:0] win_t;

    typedef struct packed {
        win_t win;
        logic encode;  // 0: end marker only, no position
        logic grp;     // position belongs to the end-of-phrase request
        logic last;    // last job of the phrase
    } job_t;

    typedef struct packed {
        logic flushing;
    } fe_stat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- sv/metaphone_phoneme_encoder_top.sv -----
// ----------------------------------------------------------------------------
// Metaphone phoneme encoder
// Streams phrase bytes in and Metaphone phoneme characters out.
// ----------------------------------------------------------------------------
// The front end takes one byte per cycle unless flushing or the queue is full
// and, once three bytes of look-ahead are present, queues the window for the
// position being encoded; the encoder turns one queued position per cycle into
// zero, one or two phonemes while its output drains, and the result port
// delivers one phoneme per cycle while m_axis_tready is high. A letter with two
// phonemes (X gives KS) holds the encoder until both pass into the single-phoneme
// result register. At the end of a phrase the front end queues a job for each
// remaining window position (an end marker alone if none remain), with input
// held off. Results of the final request are held one behind so the last one
// carries tlast; a phrase with no phoneme ends in a single result with tuser low.
`include "metaphone_phoneme_encoder_top_assert.svh"

module metaphone_phoneme_encoder_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [7:0] char_byte
    input  logic                             s_axis_tlast,   // end_of_phrase
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // [7:0] phoneme
    output logic [0:0]                       m_axis_tuser,   // [0] phoneme_valid
    output logic                             m_axis_tlast,   // phrase_done
    input  logic                             cfg_we,
    input  logic [mpe_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mpe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [mpe_pkg::LIMIT_BITS-1:0] limit_reg;
    logic                           trad_reg;

    mpe_pkg::fe_stat_t fr_stat;
    mpe_pkg::q_stat_t  q_stat;
    mpe_pkg::job_t     push_job;
    mpe_pkg::job_t     head_job;
    logic              q_push;
    logic              q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
            trad_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                mpe_pkg::REG_PHONEME_LIMIT: limit_reg <= cfg_wdata[mpe_pkg::LIMIT_BITS-1:0];
                mpe_pkg::REG_TRAD_MODE:     trad_reg  <= cfg_wdata[0];
                default:                    limit_reg <= limit_reg;
            endcase
        end
    end

    mpe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_stat        (q_stat),
        .push          (q_push),
        .push_job      (push_job),
        .stat          (fr_stat)
    );

    mpe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    mpe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .q_stat        (q_stat),
        .pop           (q_pop),
        .phoneme_limit (limit_reg),
        .trad_mode     (trad_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `MPE_ASSERT_ALWAYS(a_no_input_during_flush, !(fr_stat.flushing && s_axis_tready), "input ready while flushing")
    `MPE_ASSERT_IMPLY(a_queue_no_overflow, q_push, !q_stat.full, "job pushed into full queue")
    `MPE_ASSERT_IMPLY(a_queue_no_underflow, q_pop, !q_stat.empty, "job popped from empty queue")
    `MPE_ASSERT_IMPLY(a_empty_result_ends_phrase, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast, "empty result without tlast")

endmodule

// ----- sv/mpe_front.sv -----
// ----------------------------------------------------------------------------
// Metaphone encoder front end
// Accepts bytes, keeps the letter window and issues one job per encoded
// position, flushing the window at the end of a phrase.
// ----------------------------------------------------------------------------
module mpe_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] char_byte
    input  logic              s_axis_tlast,   // end_of_phrase
    input  mpe_pkg::q_stat_t  q_stat,
    output logic              push,
    output mpe_pkg::job_t     push_job,
    output mpe_pkg::fe_stat_t stat
);

    mpe_pkg::win_t win_reg, win_next;
    logic [1:0]    fill_reg, fill_next;
    logic          nul_reg, nul_next;
    logic          fl_reg, fl_next;
    logic          fl_first_reg, fl_first_next;
    logic [1:0]    rem_reg, rem_next;

    logic          accept;
    logic          b_ok;
    mpe_pkg::win_t win_in;
    mpe_pkg::win_t win_fl;
    logic [2:0]    fill_in;
    logic          enc;
    logic [1:0]    fill_after;
    logic [2:0]    shamt;

    assign s_axis_tready = !fl_reg && !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign stat.flushing = fl_reg;

    assign b_ok       = !nul_reg && (s_axis_tdata != 8'd0);
    assign win_in     = b_ok ? {s_axis_tdata, win_reg[mpe_pkg::WIN_LEN-1:1]} : win_reg;
    assign fill_in    = {1'b0, fill_reg} + {2'b00, b_ok};
    assign enc        = fill_in[2];
    assign fill_after = enc ? 2'd3 : fill_in[1:0];

    // first flush step pads the window so the oldest pending byte lands on CUR
    assign shamt  = fl_first_reg ? (3'd4 - {1'b0, rem_reg}) : 3'd1;
    assign win_fl = win_reg >> {shamt, 3'b000};

    always_comb
    begin
        win_next      = win_reg;
        fill_next     = fill_reg;
        nul_next      = nul_reg;
        fl_next       = fl_reg;
        fl_first_next = fl_first_reg;
        rem_next      = rem_reg;
        push          = 1'b0;
        push_job      = '0;
        if (fl_reg)
        begin
            if (!q_stat.full)
            begin
                push            = 1'b1;
                push_job.win    = win_fl;
                push_job.encode = (rem_reg != 2'd0);
                push_job.grp    = 1'b1;
                push_job.last   = (rem_reg <= 2'd1);
                if (rem_reg <= 2'd1)
                begin
                    win_next  = '0;
                    fill_next = 2'd0;
                    nul_next  = 1'b0;
                    fl_next   = 1'b0;
                end
                else
                begin
                    win_next      = win_fl;
                    rem_next      = rem_reg - 2'd1;
                    fl_first_next = 1'b0;
                end
            end
        end
        else if (accept)
        begin
            win_next  = win_in;
            fill_next = fill_after;
            nul_next  = nul_reg || (s_axis_tdata == 8'd0);
            if (enc)
            begin
                push            = 1'b1;
                push_job.win    = win_in;
                push_job.encode = 1'b1;
                push_job.grp    = s_axis_tlast;
                push_job.last   = 1'b0;
            end
            if (s_axis_tlast)
            begin
                fl_next       = 1'b1;
                fl_first_next = 1'b1;
                rem_next      = fill_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            fill_reg     <= 2'd0;
            nul_reg      <= 1'b0;
            fl_reg       <= 1'b0;
            fl_first_reg <= 1'b0;
            rem_reg      <= 2'd0;
        end
        else
        begin
            win_reg      <= win_next;
            fill_reg     <= fill_next;
            nul_reg      <= nul_next;
            fl_reg       <= fl_next;
            fl_first_reg <= fl_first_next;
            rem_reg      <= rem_next;
        end
    end

endmodule

// ----- sv/mpe_queue.sv -----
// ----------------------------------------------------------------------------
// Metaphone encoder job queue
// Short FIFO of position jobs between the front end and the encoder.
// ----------------------------------------------------------------------------
module mpe_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mpe_pkg::job_t    push_job,
    input  logic             pop,
    output mpe_pkg::job_t    head_job,
    output mpe_pkg::q_stat_t stat
);

    mpe_pkg::job_t                mem [mpe_pkg::QDEPTH];
    logic [mpe_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [mpe_pkg::QPTR_W:0]     cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == (mpe_pkg::QPTR_W + 1)'(mpe_pkg::QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- sv/mpe_back.sv -----
// ----------------------------------------------------------------------------
// Metaphone encoder back end
// Encodes one window position per job into up to two phonemes and streams
// them out one per cycle unless stalled, marking the last result of each phrase.
// ----------------------------------------------------------------------------
module mpe_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mpe_pkg::job_t                  head_job,
    input  mpe_pkg::q_stat_t               q_stat,
    output logic                           pop,
    input  logic [mpe_pkg::LIMIT_BITS-1:0] phoneme_limit,
    input  logic                           trad_mode,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [7:0] phoneme
    output logic [0:0]                     m_axis_tuser,  // [0] phoneme_valid
    output logic                           m_axis_tlast   // phrase_done
);

    localparam int CW = mpe_pkg::LIMIT_BITS + 1;

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] p0;
        logic [7:0] p1;
        logic [1:0] skip;
    } res_t;

    typedef struct packed {
        logic used;
        res_t r;
    } first_t;

    function automatic logic [7:0] f_up(input logic [7:0] c);
        return (c inside {["a":"z"]}) ? (c - 8'd32) : c;
    endfunction

    function automatic logic f_letter(input logic [7:0] c);
        return (c inside {["A":"Z"], ["a":"z"]});
    endfunction

    function automatic logic [4:0] f_cls(input logic [7:0] u);
        logic [7:0] ofs;
        ofs = u - 8'h41;
        return (u inside {["A":"Z"]}) ? mpe_pkg::LETTER_CLASS[ofs[4:0]] : 5'd0;
    endfunction

    function automatic logic f_vowel(input logic [7:0] u);
        logic [4:0] k;
        k = f_cls(u);
        return k[mpe_pkg::CLS_VOWEL_BIT];
    endfunction

    function automatic logic f_affect_h(input logic [7:0] u);
        logic [4:0] k;
        k = f_cls(u);
        return k[mpe_pkg::CLS_AFFECT_H_BIT];
    endfunction

    function automatic logic f_soft(input logic [7:0] u);
        logic [4:0] k;
        k = f_cls(u);
        return k[mpe_pkg::CLS_SOFT_BIT];
    endfunction

    function automatic logic f_no_gh_f(input logic [7:0] u);
        logic [4:0] k;
        k = f_cls(u);
        return k[mpe_pkg::CLS_NO_GH_F_BIT];
    endfunction

    function automatic res_t f_add(input res_t r, input logic [7:0] ch);
        res_t o;
        o = r;
        if (r.n == 2'd0)
        begin
            o.p0 = ch;
        end
        else
        begin
            o.p1 = ch;
        end
        o.n = r.n + 2'd1;
        return o;
    endfunction

    function automatic res_t f_main(input logic [7:0] c, input logic [7:0] prev,
                                    input logic [7:0] nx, input logic [7:0] nx2,
                                    input logic [7:0] ah3, input logic [7:0] bk3,
                                    input logic [7:0] bk4, input logic trad);
        res_t r;
        r = '0;
        if (c != prev || c == "C")
        begin
            case (c)
                "B":
                begin
                    if (prev != "M") r = f_add(r, "B");
                end
                "C":
                begin
                    if (f_soft(nx))
                    begin
                        if (nx == "I" && nx2 == "A") r = f_add(r, mpe_pkg::SH_CODE);
                        else if (prev != "S") r = f_add(r, "S");
                    end
                    else if (nx == "H")
                    begin
                        if (!trad && (prev == "S" || nx2 == "R")) r = f_add(r, "K");
                        else r = f_add(r, mpe_pkg::SH_CODE);
                        r.skip = r.skip + 2'd1;
                    end
                    else r = f_add(r, "K");
                end
                "D":
                begin
                    if (nx == "G" && f_soft(nx2))
                    begin
                        r = f_add(r, "J");
                        r.skip = r.skip + 2'd1;
                    end
                    else r = f_add(r, "T");
                end
                "G":
                begin
                    if (nx == "H")
                    begin
                        if (!(f_no_gh_f(bk3) || bk4 == "H"))
                        begin
                            r = f_add(r, "F");
                            r.skip = r.skip + 2'd1;
                        end
                    end
                    else if (nx == "N")
                    begin
                        if (!(!f_letter(nx2) || (nx2 == "E" && ah3 == "D"))) r = f_add(r, "K");
                    end
                    else if (f_soft(nx) && prev != "G") r = f_add(r, "J");
                    else r = f_add(r, "K");
                end
                "H":
                begin
                    if (f_vowel(nx) && !f_affect_h(prev)) r = f_add(r, "H");
                end
                "K":
                begin
                    if (prev != "C") r = f_add(r, "K");
                end
                "P": r = f_add(r, (nx == "H") ? 8'h46 : 8'h50);
                "Q": r = f_add(r, "K");
                "S":
                begin
                    if (nx == "I" && (nx2 == "O" || nx2 == "A")) r = f_add(r, mpe_pkg::SH_CODE);
                    else if (nx == "H")
                    begin
                        r = f_add(r, mpe_pkg::SH_CODE);
                        r.skip = r.skip + 2'd1;
                    end
                    else if (!trad && nx == "C" && nx2 == "H" && ah3 == "W")
                    begin
                        r = f_add(r, mpe_pkg::SH_CODE);
                        r.skip = r.skip + 2'd2;
                    end
                    else r = f_add(r, "S");
                end
                "T":
                begin
                    if (nx == "I" && (nx2 == "O" || nx2 == "A")) r = f_add(r, mpe_pkg::SH_CODE);
                    else if (nx == "H")
                    begin
                        r = f_add(r, mpe_pkg::TH_CODE);
                        r.skip = r.skip + 2'd1;
                    end
                    else if (!(nx == "C" && nx2 == "H")) r = f_add(r, "T");
                end
                "V": r = f_add(r, "F");
                "W":
                begin
                    if (f_vowel(nx)) r = f_add(r, "W");
                end
                "X":
                begin
                    r = f_add(r, "K");
                    r = f_add(r, "S");
                end
                "Y":
                begin
                    if (f_vowel(nx)) r = f_add(r, "Y");
                end
                "Z": r = f_add(r, "S");
                "F", "J", "L", "M", "N", "R": r = f_add(r, c);
                default: r = r;
            endcase
        end
        return r;
    endfunction

    function automatic first_t f_first(input logic [7:0] c, input logic [7:0] nx);
        first_t f;
        f = '0;
        case (c)
            "A":
            begin
                f.used = 1'b1;
                if (nx == "E")
                begin
                    f.r = f_add(f.r, "E");
                    f.r.skip = 2'd1;
                end
                else f.r = f_add(f.r, "A");
            end
            "G", "K", "P":
            begin
                if (nx == "N")
                begin
                    f.used = 1'b1;
                    f.r = f_add(f.r, "N");
                    f.r.skip = 2'd1;
                end
            end
            "W":
            begin
                if (nx == "R")
                begin
                    f.used = 1'b1;
                    f.r = f_add(f.r, "R");
                    f.r.skip = 2'd1;
                end
                else if (nx == "H" || f_vowel(nx))
                begin
                    f.used = 1'b1;
                    f.r = f_add(f.r, "W");
                    f.r.skip = 2'd1;
                end
            end
            "X":
            begin
                f.used = 1'b1;
                f.r = f_add(f.r, "S");
            end
            "E", "I", "O", "U":
            begin
                f.used = 1'b1;
                f.r = f_add(f.r, c);
            end
            default: f = f;
        endcase
        return f;
    endfunction

    // phrase state
    logic          first_reg, first_next;
    logic [1:0]    skip_reg, skip_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    seen_reg, seen_next;
    logic          lr_reg, lr_next;

    // emit stage
    logic [7:0]    ph0_reg, ph0_next;
    logic [7:0]    ph1_reg, ph1_next;
    logic [1:0]    bn_reg, bn_next;
    logic          bfin_reg, bfin_next;
    logic          bgrp_reg, bgrp_next;
    logic          pend_v_reg, pend_v_next;
    logic [7:0]    pend_reg, pend_next;

    // output register
    logic          ov_reg, ov_next;
    logic [7:0]    od_reg, od_next;
    logic          ou_reg, ou_next;
    logic          ol_reg, ol_next;

    mpe_pkg::win_t w;
    logic [7:0]    raw, c_up, prev, bk3, bk4, nx, nx2, ah3;
    logic          raw_letter;
    logic          lim_hit;
    res_t          main_r;
    first_t        first_r;

    res_t          pos_r;
    logic          pos_first;
    logic [1:0]    pos_skip;
    logic          pos_lr;
    logic [CW:0]   cnt_sum;
    logic [CW-1:0] cnt_pos;
    logic [2:0]    seen_pos;

    logic          out_free;
    logic          busy;
    logic          a_go;

    assign w          = head_job.win;
    assign raw        = w[mpe_pkg::CUR];
    assign c_up       = f_up(raw);
    assign raw_letter = f_letter(raw);
    assign prev = (seen_reg >= 3'd1) ? f_up(w[mpe_pkg::CUR-1]) : 8'd0;
    assign bk3  = (seen_reg >= 3'd3) ? f_up(w[mpe_pkg::CUR-3]) : 8'd0;
    assign bk4  = (seen_reg >= 3'd4) ? f_up(w[mpe_pkg::CUR-4]) : 8'd0;
    assign nx   = f_up(w[mpe_pkg::CUR+1]);
    assign nx2  = (w[mpe_pkg::CUR+1] != 8'd0) ? f_up(w[mpe_pkg::CUR+2]) : 8'd0;
    // look-ahead stops at the first zero byte
    assign ah3  = (w[mpe_pkg::CUR+1] != 8'd0 && w[mpe_pkg::CUR+2] != 8'd0)
                ? f_up(w[mpe_pkg::CUR+3]) : 8'd0;

    assign main_r  = f_main(c_up, prev, nx, nx2, ah3, bk3, bk4, trad_mode);
    assign first_r = f_first(c_up, nx);
    assign lim_hit = (phoneme_limit != '0) && (cnt_reg >= {1'b0, phoneme_limit});

    always_comb
    begin
        pos_r     = '0;
        pos_first = first_reg;
        pos_skip  = skip_reg;
        pos_lr    = lr_reg;
        if (head_job.encode)
        begin
            if (skip_reg != 2'd0)
            begin
                pos_skip = skip_reg - 2'd1;
            end
            else if (!first_reg)
            begin
                if (raw_letter)
                begin
                    pos_first = 1'b1;
                    if (first_r.used)
                    begin
                        pos_r    = first_r.r;
                        pos_skip = first_r.r.skip;
                    end
                    else
                    begin
                        pos_lr = lr_reg || lim_hit;
                        if (!pos_lr)
                        begin
                            pos_r    = main_r;
                            pos_skip = main_r.skip;
                        end
                    end
                end
            end
            else
            begin
                pos_lr = lr_reg || lim_hit;
                if (!pos_lr && raw_letter)
                begin
                    pos_r    = main_r;
                    pos_skip = main_r.skip;
                end
            end
        end
    end

    assign cnt_sum  = {1'b0, cnt_reg} + {{(CW-1){1'b0}}, pos_r.n};
    assign cnt_pos  = cnt_sum[CW] ? '1 : cnt_sum[CW-1:0];
    assign seen_pos = (head_job.encode && seen_reg != 3'd4) ? seen_reg + 3'd1 : seen_reg;

    assign out_free = !ov_reg || m_axis_tready;
    assign busy     = (bn_reg != 2'd0) || bfin_reg;

    always_comb
    begin
        first_next  = first_reg;
        skip_next   = skip_reg;
        cnt_next    = cnt_reg;
        seen_next   = seen_reg;
        lr_next     = lr_reg;
        ph0_next    = ph0_reg;
        ph1_next    = ph1_reg;
        bn_next     = bn_reg;
        bfin_next   = bfin_reg;
        bgrp_next   = bgrp_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        ov_next     = ov_reg && !m_axis_tready;
        od_next     = od_reg;
        ou_next     = ou_reg;
        ol_next     = ol_reg;

        if (busy && out_free)
        begin
            if (bn_reg != 2'd0)
            begin
                ph0_next = ph1_reg;
                bn_next  = bn_reg - 2'd1;
                if (!bgrp_reg)
                begin
                    ov_next = 1'b1;
                    od_next = ph0_reg;
                    ou_next = 1'b1;
                    ol_next = 1'b0;
                end
                else
                begin
                    // end-of-phrase results wait one behind, so the last can carry done
                    if (pend_v_reg)
                    begin
                        ov_next = 1'b1;
                        od_next = pend_reg;
                        ou_next = 1'b1;
                        ol_next = 1'b0;
                    end
                    pend_v_next = 1'b1;
                    pend_next   = ph0_reg;
                end
            end
            else
            begin
                bfin_next   = 1'b0;
                pend_v_next = 1'b0;
                ov_next     = 1'b1;
                od_next     = pend_v_reg ? pend_reg : 8'd0;
                ou_next     = pend_v_reg;
                ol_next     = 1'b1;
            end
        end

        a_go = !q_stat.empty && (bn_next == 2'd0) && !bfin_next;
        if (a_go)
        begin
            ph0_next  = pos_r.p0;
            ph1_next  = pos_r.p1;
            bn_next   = pos_r.n;
            bfin_next = head_job.last;
            bgrp_next = head_job.grp;
            if (head_job.last)
            begin
                first_next = 1'b0;
                skip_next  = 2'd0;
                cnt_next   = '0;
                seen_next  = 3'd0;
                lr_next    = 1'b0;
            end
            else
            begin
                first_next = pos_first;
                skip_next  = pos_skip;
                cnt_next   = cnt_pos;
                seen_next  = seen_pos;
                lr_next    = pos_lr;
            end
        end
    end

    assign pop           = a_go;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tlast  = ol_reg;

    always_ff @(posedge clk)
    begin
        ph0_reg  <= ph0_next;
        ph1_reg  <= ph1_next;
        pend_reg <= pend_next;
        od_reg   <= od_next;
        ou_reg   <= ou_next;
        ol_reg   <= ol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= 1'b0;
            skip_reg   <= 2'd0;
            cnt_reg    <= '0;
            seen_reg   <= 3'd0;
            lr_reg     <= 1'b0;
            bn_reg     <= 2'd0;
            bfin_reg   <= 1'b0;
            bgrp_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            first_reg  <= first_next;
            skip_reg   <= skip_next;
            cnt_reg    <= cnt_next;
            seen_reg   <= seen_next;
            lr_reg     <= lr_next;
            bn_reg     <= bn_next;
            bfin_reg   <= bfin_next;
            bgrp_reg   <= bgrp_next;
            pend_v_reg <= pend_v_next;
            ov_reg     <= ov_next;
        end
    end

endmodule
